// ===== rtl/arc_pkg.sv =====
// Shared types and constants of the arithmetic range encoder.
package arc_pkg;

	localparam int FIELD_W     = 16;
	localparam int MAX_RESULTS = 40;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	typedef struct packed {
		logic               action;
		logic [FIELD_W-1:0] upper_cum;
		logic [FIELD_W-1:0] lower_cum;
		logic [FIELD_W-1:0] total_freq;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_result;
		logic [1:0] status;
	} out_item_t;

endpackage

// ===== rtl/arith_range_encoder_unit.sv =====
// Top level of the arithmetic range encoder: sequencer, bit packer, byte buffer.
//
// channel | dir | handshake            | payload
// sym     | in  | sym_valid/sym_ready  | arc_pkg::in_item_t
// res     | out | res_valid/res_ready  | arc_pkg::out_item_t
//
// An encode item runs two serial multiply-divides (start, 16 multiply steps,
// CODE_BITS + 17 divide steps, done), then renormalizes one step or follow bit
// at a time, then reads and loads each buffered byte in turn. Bad bounds caught
// at accept skip the divider and give a status-only result. A finish item emits
// its final and follow bits, flushes the partial byte and drains the buffer.
// sym_ready is high only while the sequencer is idle; a stalled res holds the drain.
// Reset leaves the interval at full range with no pending bits.
module arith_range_encoder_unit #(
	parameter int CODE_BITS  = 32,
	parameter int FREQ_BITS  = 16,
	parameter int MAX_FOLLOW = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sym_valid,
	output logic               sym_ready,
	input  arc_pkg::in_item_t  sym,
	output logic               res_valid,
	input  logic               res_ready,
	output arc_pkg::out_item_t res
);

	localparam int CW    = CODE_BITS;
	localparam int AW    = CW + 1;
	localparam int FW    = arc_pkg::FIELD_W;
	localparam int PFW   = $clog2(MAX_FOLLOW + 1);
	localparam int GUARD = 2 * CW + 2;
	localparam int GW    = $clog2(GUARD + 1);
	localparam int MR    = arc_pkg::MAX_RESULTS;
	localparam int EW    = $clog2(MR + 1);
	localparam int RA    = $clog2(MR);
	localparam logic [CW-1:0] HALF  = CW'(1) << (CW - 1);
	localparam logic [CW-1:0] QTR   = CW'(1) << (CW - 2);
	localparam logic [CW-1:0] TQTR  = HALF | QTR;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV_HI, S_WAIT_HI, S_DIV_LO, S_WAIT_LO, S_APPLY, S_RENORM,
		S_FOLLOW, S_FIN_BIT, S_FIN_BYTE, S_END, S_NOBYTE, S_RD, S_LOAD
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      low_q, high_q;
	logic [PFW-1:0]     pend_q;
	logic [7:0]         shift_q;
	logic [3:0]         bl_q;
	logic [FW-1:0]      upper_q, lower_q, total_q;
	logic [AW-1:0]      ran_q, nh_q;
	logic [GW-1:0]      guard_q;
	logic               fbit_q, ret_fin_q, bad_q, sat_q;
	logic [EW-1:0]      emit_q, rd_q;
	logic               res_valid_q;
	arc_pkg::out_item_t res_q;

	logic          md_start, md_busy, md_done;
	logic [AW-1:0] md_q;
	logic          pb_bit, pb_do, pb_rec;
	logic [3:0]    bl_n, pb_bl;
	logic [7:0]    pb_shift;
	logic          we;
	logic [7:0]    wdata;
	logic [7:0]    rdata;
	logic          out_free;
	logic          res_load;
	logic [1:0]    status;
	logic          fail;

	arc_muldiv #(.AW(AW)) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (md_start),
		.a     (ran_q),
		.b     (state_q == S_DIV_HI ? upper_q : lower_q),
		.d     (total_q),
		.busy  (md_busy),
		.done  (md_done),
		.q     (md_q)
	);

	arc_ram #(.WIDTH(8), .DEPTH(MR)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(emit_q[RA-1:0]),
		.wdata(wdata),
		.raddr(rd_q[RA-1:0]),
		.rdata(rdata)
	);

	assign md_start  = state_q == S_DIV_HI || state_q == S_DIV_LO;
	assign sym_ready = state_q == S_IDLE;
	assign out_free  = !res_valid_q || res_ready;
	assign res_load  = out_free && (state_q == S_NOBYTE || state_q == S_LOAD);
	assign status    = bad_q ? arc_pkg::ST_BAD : (sat_q ? arc_pkg::ST_SAT : arc_pkg::ST_OK);
	assign fail      = sym.total_freq == '0 || sym.upper_cum > sym.total_freq ||
		sym.lower_cum >= sym.upper_cum || high_q < low_q ||
		((FREQ_BITS < FW) && ((sym.total_freq >> FREQ_BITS) != '0));

	// bit packer: one bit per cycle in the renorm, follow and final-bit states, first bit ends in bit 0
	always_comb begin
		pb_do  = 1'b0;
		pb_bit = 1'b0;
		unique case (state_q)
			S_RENORM: begin
				pb_do  = guard_q != GW'(GUARD) && (high_q < HALF || low_q >= HALF);
				pb_bit = !(high_q < HALF);
			end
			S_FOLLOW: begin
				pb_do  = 1'b1;
				pb_bit = fbit_q;
			end
			S_FIN_BIT: begin
				pb_do  = 1'b1;
				pb_bit = low_q >= QTR;
			end
			default: ;
		endcase
		bl_n     = (bl_q == 4'd0 || bl_q > 4'd8) ? 4'd8 : bl_q;
		pb_shift = {pb_bit, shift_q[7:1]};
		pb_bl    = bl_n - 4'd1;
		pb_rec   = pb_do && pb_bl == 4'd0;
		if (state_q == S_FIN_BYTE) begin
			wdata = shift_q >> bl_n;
			we    = emit_q < EW'(MR);
		end else begin
			wdata = pb_shift;
			we    = pb_rec && emit_q < EW'(MR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			low_q       <= '0;
			high_q      <= '1;
			pend_q      <= '0;
			shift_q     <= '0;
			bl_q        <= 4'd8;
			upper_q     <= '0;
			lower_q     <= '0;
			total_q     <= '0;
			ran_q       <= '0;
			nh_q        <= '0;
			guard_q     <= '0;
			fbit_q      <= 1'b0;
			ret_fin_q   <= 1'b0;
			bad_q       <= 1'b0;
			sat_q       <= 1'b0;
			emit_q      <= '0;
			rd_q        <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && res_ready && !res_load) begin
				res_valid_q <= 1'b0;
			end
			if (pb_do) begin
				shift_q <= pb_shift;
				bl_q    <= pb_rec ? 4'd8 : pb_bl;
			end
			if (we) begin
				emit_q <= emit_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sym_valid) begin
						emit_q  <= '0;
						bad_q   <= 1'b0;
						sat_q   <= 1'b0;
						guard_q <= '0;
						upper_q <= sym.upper_cum;
						lower_q <= sym.lower_cum;
						total_q <= sym.total_freq;
						ran_q   <= {1'b0, high_q} - {1'b0, low_q} + AW'(1);
						if (sym.action == arc_pkg::ACT_FINISH) begin
							if (pend_q >= PFW'(MAX_FOLLOW)) begin
								pend_q <= PFW'(MAX_FOLLOW);
								sat_q  <= 1'b1;
							end else begin
								pend_q <= pend_q + 1'b1;
							end
							state_q <= S_FIN_BIT;
						end else if (fail) begin
							bad_q   <= 1'b1;
							state_q <= S_NOBYTE;
						end else begin
							state_q <= S_DIV_HI;
						end
					end
				end
				S_DIV_HI: state_q <= S_WAIT_HI;
				S_WAIT_HI: begin
					if (md_done) begin
						nh_q    <= md_q;
						state_q <= S_DIV_LO;
					end
				end
				S_DIV_LO: state_q <= S_WAIT_LO;
				S_WAIT_LO: begin
					if (md_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (nh_q <= md_q) begin
						bad_q   <= 1'b1;
						state_q <= S_NOBYTE;
					end else begin
						high_q  <= CW'({1'b0, low_q} + nh_q - AW'(1));
						low_q   <= CW'({1'b0, low_q} + md_q);
						state_q <= S_RENORM;
					end
				end
				S_RENORM: begin
					ret_fin_q <= 1'b0;
					if (guard_q == GW'(GUARD)) begin
						state_q <= S_END;
					end else if (high_q < HALF || low_q >= HALF) begin
						// subtracting half is dropped by the shift
						fbit_q  <= high_q < HALF;
						low_q   <= {low_q[CW-2:0], 1'b0};
						high_q  <= {high_q[CW-2:0], 1'b1};
						guard_q <= guard_q + 1'b1;
						if (pend_q != '0) begin
							state_q <= S_FOLLOW;
						end
					end else if (low_q >= QTR && high_q < TQTR) begin
						if (pend_q >= PFW'(MAX_FOLLOW)) begin
							pend_q <= PFW'(MAX_FOLLOW);
							sat_q  <= 1'b1;
						end else begin
							pend_q <= pend_q + 1'b1;
						end
						low_q   <= {low_q[CW-2:0] - QTR[CW-2:0], 1'b0};
						high_q  <= {high_q[CW-2:0] - QTR[CW-2:0], 1'b1};
						guard_q <= guard_q + 1'b1;
					end else begin
						state_q <= S_END;
					end
				end
				S_FOLLOW: begin
					pend_q <= pend_q - 1'b1;
					if (pend_q == PFW'(1)) begin
						state_q <= ret_fin_q ? S_FIN_BYTE : S_RENORM;
					end
				end
				S_FIN_BIT: begin
					fbit_q    <= !(low_q >= QTR);
					ret_fin_q <= 1'b1;
					state_q   <= (pend_q != '0) ? S_FOLLOW : S_FIN_BYTE;
				end
				S_FIN_BYTE: begin
					low_q   <= '0;
					high_q  <= '1;
					pend_q  <= '0;
					shift_q <= '0;
					bl_q    <= 4'd8;
					rd_q    <= '0;
					state_q <= S_RD;
				end
				S_END: begin
					rd_q <= '0;
					if (emit_q != '0) begin
						state_q <= S_RD;
					end else if (status != arc_pkg::ST_OK) begin
						state_q <= S_NOBYTE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_NOBYTE: begin
					if (out_free) begin
						res_q.out_byte    <= '0;
						res_q.byte_valid  <= 1'b0;
						res_q.last_result <= 1'b1;
						res_q.status      <= status;
						res_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				S_RD: state_q <= S_LOAD;
				S_LOAD: begin
					if (out_free) begin
						res_q.out_byte    <= rdata;
						res_q.byte_valid  <= 1'b1;
						res_q.last_result <= EW'(rd_q + 1'b1) == emit_q;
						res_q.status      <= status;
						res_valid_q       <= 1'b1;
						rd_q              <= rd_q + 1'b1;
						state_q           <= (EW'(rd_q + 1'b1) == emit_q) ? S_IDLE : S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_pend_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PFW'(MAX_FOLLOW))
		else $error("follow count above limit");

	a_emit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q <= EW'(MR))
		else $error("byte buffer overrun");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		sym_ready |-> !md_busy)
		else $error("divider busy while idle");

	a_drain_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> rd_q < emit_q)
		else $error("drain index past buffered bytes");

endmodule

// ===== rtl/arc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module arc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/arc_muldiv.sv =====
// Serial multiply then restoring divide: q = (a * b) / d, one bit per cycle.
module arc_muldiv #(
	parameter int AW = 33
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [AW-1:0]               a,
	input  logic [arc_pkg::FIELD_W-1:0] b,
	input  logic [arc_pkg::FIELD_W-1:0] d,
	output logic                        busy,
	output logic                        done,
	output logic [AW-1:0]               q
);

	localparam int FW = arc_pkg::FIELD_W;
	localparam int PW = AW + FW;
	localparam int CW = $clog2(PW + 1);

	typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

	md_state_t     state_q;
	logic [PW-1:0] acc_q;
	logic [PW-1:0] mcand_q;
	logic [FW-1:0] mplier_q;
	logic [FW-1:0] dvsr_q;
	logic [FW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [FW:0] trial;
	logic        fits;

	assign trial = {rem_q, acc_q[PW-1]};
	assign fits  = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= MD_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			acc_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			dvsr_q   <= '0;
			rem_q    <= '0;
		end else begin
			done_q <= state_q == MD_DIV && cnt_q == CW'(PW - 1);
			unique case (state_q)
				MD_IDLE: begin
					if (start) begin
						acc_q    <= '0;
						mcand_q  <= PW'(a);
						mplier_q <= b;
						dvsr_q   <= d;
						cnt_q    <= '0;
						state_q  <= MD_MUL;
					end
				end
				MD_MUL: begin
					if (mplier_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					mcand_q  <= {mcand_q[PW-2:0], 1'b0};
					mplier_q <= mplier_q >> 1;
					if (cnt_q == CW'(FW - 1)) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						state_q <= MD_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				MD_DIV: begin
					// shift product out at the top, quotient bits in at the bottom
					rem_q <= fits ? FW'(trial - {1'b0, dvsr_q}) : trial[FW-1:0];
					acc_q <= {acc_q[PW-2:0], fits};
					if (cnt_q == CW'(PW - 1)) begin
						state_q <= MD_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	assign busy = state_q != MD_IDLE;
	assign done = done_q;
	assign q    = acc_q[AW-1:0];

endmodule

// ===== bench/tb_arith_range_encoder_unit.sv =====
// Self-checking testbench for the arithmetic range encoder unit.
`timescale 1ns / 1ps

module tb_arith_range_encoder_unit;

	localparam int         CODE_W     = 32;
	localparam int         FOLLOW_MAX = 255;
	localparam logic [63:0] TOP_CODE  = (64'd1 << CODE_W) - 64'd1;
	localparam logic [63:0] HALF_CODE = 64'd1 << (CODE_W - 1);
	localparam logic [63:0] QTR_CODE  = 64'd1 << (CODE_W - 2);
	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         TAIL_CYCLES = 400;

	class code_byte_board;
		logic [63:0] lo, hi;
		int unsigned follows, shift_reg, bits_free;
		arc_pkg::out_item_t bytes_due[$];
		logic [7:0]  emitted[$];
		bit          saturated;
		int          fails;

		function new();
			clear_interval();
		endfunction

		function void clear_interval();
			lo = 0;
			hi = TOP_CODE;
			follows = 0;
			shift_reg = 0;
			bits_free = 8;
		endfunction

		function void push_bit(bit b);
			shift_reg = ((shift_reg >> 1) | (b ? 32'h80 : 32'h0)) & 32'hFF;
			bits_free--;
			if (bits_free == 0) begin
				emitted.push_back(shift_reg[7:0]);
				bits_free = 8;
			end
		endfunction

		function void push_settled(bit b);
			push_bit(b);
			while (follows != 0) begin
				push_bit(!b);
				follows--;
			end
		endfunction

		function void add_follow();
			if (follows >= FOLLOW_MAX) begin
				follows = FOLLOW_MAX;
				saturated = 1;
			end else begin
				follows++;
			end
		endfunction

		// Narrow and renormalize; return 0 when the bounds are rejected.
		function bit narrow(logic [63:0] up, logic [63:0] dn, logic [63:0] tot);
			logic [63:0] span, top_off, bot_off;
			if (tot == 0 || up > tot || dn >= up || hi < lo)
				return 0;
			span = hi - lo + 1;
			top_off = (span * up) / tot;
			bot_off = (span * dn) / tot;
			if (top_off <= bot_off)
				return 0;
			hi = lo + top_off - 1;
			lo = lo + bot_off;
			for (int g = 0; g < 2 * CODE_W + 2; g++) begin
				if (hi < HALF_CODE) begin
					push_settled(0);
				end else if (lo >= HALF_CODE) begin
					push_settled(1);
					lo -= HALF_CODE;
					hi -= HALF_CODE;
				end else if (lo >= QTR_CODE && hi < 3 * QTR_CODE) begin
					add_follow();
					lo -= QTR_CODE;
					hi -= QTR_CODE;
				end else begin
					break;
				end
				lo = (lo << 1) & TOP_CODE;
				hi = ((hi << 1) | 1) & TOP_CODE;
			end
			return 1;
		endfunction

		function void note_symbol(arc_pkg::in_item_t it);
			logic [1:0] st;
			arc_pkg::out_item_t r;
			bit         bad;
			emitted.delete();
			saturated = 0;
			bad = 0;
			if (it.action == arc_pkg::ACT_FINISH) begin
				add_follow();
				push_settled(lo < QTR_CODE ? 1'b0 : 1'b1);
				emitted.push_back(8'(shift_reg >> bits_free));
				clear_interval();
			end else begin
				bad = !narrow(it.upper_cum, it.lower_cum, it.total_freq);
			end
			st = bad ? arc_pkg::ST_BAD : (saturated ? arc_pkg::ST_SAT : arc_pkg::ST_OK);
			if (emitted.size() == 0 && st != arc_pkg::ST_OK) begin
				r = '{out_byte: 8'd0, byte_valid: 1'b0, last_result: 1'b1, status: st};
				bytes_due.push_back(r);
			end
			for (int k = 0; k < emitted.size() && k < arc_pkg::MAX_RESULTS; k++) begin
				r.out_byte    = emitted[k];
				r.byte_valid  = 1'b1;
				r.last_result = (k == emitted.size() - 1);
				r.status      = st;
				bytes_due.push_back(r);
			end
		endfunction

		function void check_byte(arc_pkg::out_item_t got);
			arc_pkg::out_item_t want;
			if (bytes_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				fails++;
				return;
			end
			want = bytes_due.pop_front();
			if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
					got.last_result !== want.last_result || got.status !== want.status) begin
				$display({"%0t: mismatch expected byte=%h valid=%b last=%b status=%0d,",
					" actual byte=%h valid=%b last=%b status=%0d"},
					$time, want.out_byte, want.byte_valid, want.last_result, want.status,
					got.out_byte, got.byte_valid, got.last_result, got.status);
				fails++;
			end
		endfunction
	endclass

	logic      clk = 0;
	logic      arst_n = 0;
	logic      sym_valid = 0;
	logic      sym_ready;
	arc_pkg::in_item_t  sym = '0;
	logic      res_valid;
	logic      res_ready = 0;
	arc_pkg::out_item_t res;

	int             send_idle_pct = 38;
	int             recv_idle_pct = 45;
	int unsigned    cycles = 0;
	code_byte_board book = new();

	arith_range_encoder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.sym_valid(sym_valid), .sym_ready(sym_ready), .sym(sym),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always #1 clk = ~clk;

	always @(negedge clk)
		res_ready = ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			book.check_byte(res);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_symbol(arc_pkg::in_item_t it);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			sym_valid = 0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
		@(negedge clk);
		sym_valid = 1;
		sym = it;
		do @(posedge clk); while (!sym_ready);
		book.note_symbol(it);
	endtask

	function automatic arc_pkg::in_item_t make_item(logic act, int up, int dn, int tot);
		arc_pkg::in_item_t it;
		it.action = act;
		it.upper_cum = up[15:0];
		it.lower_cum = dn[15:0];
		it.total_freq = tot[15:0];
		return it;
	endfunction

	// Random item: mostly legal symbols, some that pile up follow bits, some finish items, some junk.
	function automatic arc_pkg::in_item_t random_symbol();
		int pick, tot, up, c;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			tot = $urandom_range(1, 65535);
			up = $urandom_range(1, tot);
			return make_item(arc_pkg::ACT_ENCODE, up, $urandom_range(0, up - 1), tot);
		end else if (pick < 75) begin
			c = $urandom_range(32700, 32830);
			return make_item(arc_pkg::ACT_ENCODE, c + $urandom_range(1, 3), c, 65535);
		end else if (pick < 83) begin
			return make_item(arc_pkg::ACT_FINISH, $urandom, $urandom, $urandom);
		end else if (pick < 88) begin
			return make_item(arc_pkg::ACT_ENCODE, $urandom, $urandom, 0);
		end else if (pick < 94) begin
			tot = $urandom_range(1, 65534);
			return make_item(arc_pkg::ACT_ENCODE, $urandom_range(tot + 1, 65535), 0, tot);
		end else begin
			up = $urandom_range(0, 65535);
			return make_item(arc_pkg::ACT_ENCODE, up, $urandom_range(up, 65535), 65535);
		end
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_symbol(make_item(arc_pkg::ACT_FINISH, 0, 0, 1));
		send_symbol(make_item(arc_pkg::ACT_ENCODE, 1, 0, 0));
		send_symbol(make_item(arc_pkg::ACT_ENCODE, 65535, 0, 65534));
		send_symbol(make_item(arc_pkg::ACT_ENCODE, 300, 300, 1000));
		send_symbol(make_item(arc_pkg::ACT_ENCODE, 65535, 65535, 65535));
		send_symbol(make_item(arc_pkg::ACT_ENCODE, 65535, 0, 65535));
		send_symbol(make_item(arc_pkg::ACT_ENCODE, 1, 0, 1));
		send_symbol(make_item(arc_pkg::ACT_ENCODE, 1, 0, 65535));
		send_symbol(make_item(arc_pkg::ACT_ENCODE, 65535, 65534, 65535));
		// Hover around the midpoint until the follow count saturates.
		repeat (20) send_symbol(make_item(arc_pkg::ACT_ENCODE, 32769, 32767, 65535));
		send_symbol(make_item(arc_pkg::ACT_FINISH, 65535, 65535, 65535));

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 45 : 0;
			recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 38 : 0;
			repeat (65) send_symbol(random_symbol());
		end
		send_symbol(make_item(arc_pkg::ACT_FINISH, 0, 0, 1));
		@(negedge clk);
		sym_valid = 0;

		while (book.bytes_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.fails == 0 && book.bytes_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
